// File: hdl/opp_pkg.sv
package opp_pkg;

    localparam int VALUE_FRAC_BITS = 16;
    localparam int VALUE_W         = 32;
    localparam int MIN_GAP_W       = 16;
    localparam int RATE_W          = 7;

    localparam logic [VALUE_W-1:0] ONE_FIXED  = VALUE_W'(64'd1 << VALUE_FRAC_BITS);
    localparam logic [VALUE_W-1:0] PEAK_RESET =
        VALUE_W'(((64'd1 << VALUE_FRAC_BITS) + 64'd50) / 64'd100);

    localparam logic [MIN_GAP_W-1:0] MIN_GAP_RESET     = 16'd12;
    localparam logic [RATE_W-1:0]    FOLLOW_RATE_RESET = 7'd6;
    localparam logic [RATE_W-1:0]    RATE_MAX          = 7'd100;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_GAP     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOLLOW_RATE = 8'd1;

    // update arithmetic, all exact integer
    // each dividend keeps 32 bits above the width of its divisor
    localparam int          ACC_W          = 52;
    localparam int          FOL_ACC_W      = VALUE_W + 7;
    localparam int          DIV_STEPS      = 3;
    localparam int unsigned AVG_GAIN       = 998001;
    localparam int unsigned DATA_GAIN      = 1000;
    localparam int unsigned AVG_ROUND      = 500000;
    localparam int unsigned AVG_DIVISOR    = 1000000;
    localparam int unsigned FOLLOW_ROUND   = 50;
    localparam int unsigned FOLLOW_DIVISOR = 100;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] hop;
        logic [VALUE_W-1:0] peak;
    } t_hop_item;

    typedef struct packed {
        logic [MIN_GAP_W-1:0] min_gap;
        logic [RATE_W-1:0]    follow_rate;
    } t_cfg;

    typedef struct packed {
        logic               onset;
        logic [VALUE_W-1:0] hop;
        logic [VALUE_W-1:0] follower;
        logic [VALUE_W-1:0] peak;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
        logic onset_seen;
    } t_back_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

// File: hdl/onset_peak_picker.sv
// channel   direction  handshake                           payload
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready   tdata: detection_value
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready   tdata: hop, follower, peak; tuser: onset
// cfg       in         i_cfg_valid / o_cfg_ready           i_cfg_index, i_cfg_data
//
// each hop passes the back end in order: it is taken, the onset test runs and the update
// dividends are formed; the two constant dividers then form a reciprocal estimate, a
// remainder and the final quotient; last, the commit step updates the follower and average
// and loads the output register. the back end takes no new hop until it has committed the
// last one, and a queue of QUEUE_DEPTH entries absorbs bursts.
// a stalled output holds the back end at commit; input stalls only once the queue is full.
// reset is synchronous and active low; ports are held not ready during reset.
module onset_peak_picker
    import opp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [VALUE_W-1:0]     i_s_axis_tdata,   // [31:0] detection_value
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [3*VALUE_W-1:0]   o_m_axis_tdata,   // [31:0] hop_index, [63:32] follower_value,
                                                     // [95:64] peak_value
    output logic                   o_m_axis_tuser,   // [0] onset
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic         r_live;
    t_cfg         r_cfg, n_cfg;
    logic         q_room, q_push, q_valid, q_pop;
    t_hop_item    q_in, q_out;
    t_result      res;
    t_back_status bst;
    logic         cfg_xfer, in_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
        end
    end

    assign o_cfg_ready = r_live;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_xfer) begin
            unique case (i_cfg_index)
                CFG_MIN_GAP:     n_cfg.min_gap     = i_cfg_data[MIN_GAP_W-1:0];
                CFG_FOLLOW_RATE: n_cfg.follow_rate = i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_gap     <= MIN_GAP_RESET;
            r_cfg.follow_rate <= FOLLOW_RATE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    opp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enable (r_live),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_value  (i_s_axis_tdata),
        .i_room   (q_room),
        .o_push   (q_push),
        .o_item   (q_in)
    );

    opp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_room  (q_room),
        .o_valid (q_valid),
        .o_item  (q_out),
        .i_pop   (q_pop)
    );

    opp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (q_valid),
        .o_item_ready (q_pop),
        .i_item       (q_out),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res        (res),
        .o_status     (bst)
    );

    assign o_m_axis_tdata = {res.peak, res.follower, res.hop};
    assign o_m_axis_tuser = res.onset;

    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // a result flagged as an onset implies the gap tracker has seen one
    a_onset_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> bst.onset_seen)
        else $error("onset result without recorded onset");

    // a hop arriving at an empty, idle pipeline is queued, then taken by the back end, which leaves idle
    a_pickup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !q_valid && bst.idle) |-> ##2 !bst.idle)
        else $error("queued hop not picked up by the back end");

    // the output register is only loaded from the commit step
    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(bst.done))
        else $error("result appeared without a commit");

endmodule

// File: hdl/opp_front.sv
module opp_front
    import opp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_enable,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_room,
    output logic               o_push,
    output t_hop_item          o_item
);

    logic [VALUE_W-1:0] r_hop, n_hop;
    logic [VALUE_W-1:0] r_peak, n_peak;
    logic               accept;

    assign o_ready = i_enable && i_room;
    assign accept  = i_valid && o_ready;

    // hop numbering and the running peak depend on the input alone
    always_comb begin
        n_hop  = r_hop;
        n_peak = r_peak;
        if (accept) begin
            n_hop = r_hop + VALUE_W'(1);
            if (i_value > r_peak) begin
                n_peak = i_value;
            end
        end
    end

    assign o_push       = accept;
    assign o_item.value = i_value;
    assign o_item.hop   = r_hop;
    assign o_item.peak  = (i_value > r_peak) ? i_value : r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop  <= '0;
            r_peak <= PEAK_RESET;
        end else begin
            r_hop  <= n_hop;
            r_peak <= n_peak;
        end
    end

endmodule

// File: hdl/opp_queue.sv
module opp_queue
    import opp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_hop_item i_item,
    output logic      o_room,
    output logic      o_valid,
    output t_hop_item o_item,
    input  logic      i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_hop_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_room  = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && o_room;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: hdl/opp_cdiv.sv
module opp_cdiv
    import opp_pkg::*;
#(
    parameter int          DIVIDEND_W = ACC_W,
    parameter int unsigned DIVISOR    = AVG_DIVISOR,
    parameter int          QUOT_W     = VALUE_W
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic                  i_step,
    output logic [QUOT_W-1:0]     o_quotient
);

    // divisor lies in (2^(SHIFT-1), 2^SHIFT], so the reciprocal scaled by 2^(31+SHIFT)
    // fits 32 bits and the estimate from the top bits falls at most four short
    localparam int SHIFT  = $clog2(DIVISOR);
    localparam int HI_W   = DIVIDEND_W - SHIFT;
    localparam int FRAC   = 31;
    localparam int PROD_W = HI_W + 32;
    localparam int REM_W  = SHIFT + 3;
    localparam logic [31:0] RECIP = 32'((64'd1 << (FRAC + SHIFT)) / 64'(DIVISOR));

    logic [DIVIDEND_W-1:0] r_num;
    logic [QUOT_W-1:0]     r_est, r_quo;
    logic [REM_W-1:0]      r_rem;
    logic [PROD_W-1:0]     prod;
    logic [DIVIDEND_W-1:0] est_back;
    logic [DIVIDEND_W-1:0] rem_full;
    logic [2:0]            adj;

    assign prod     = PROD_W'(r_num[DIVIDEND_W-1:SHIFT]) * PROD_W'(RECIP);
    assign est_back = DIVIDEND_W'(r_est) * DIVIDEND_W'(DIVISOR);
    assign rem_full = r_num - est_back;

    // remainder of the estimate is below five divisors
    always_comb begin
        adj = '0;
        for (int k = 1; k <= 4; k++) begin
            if (r_rem >= REM_W'(k * DIVISOR)) begin
                adj = adj + 3'd1;
            end
        end
    end

    // estimate, remainder and final quotient settle one step apart while the dividend holds
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num <= i_dividend;
        end else if (i_step) begin
            r_est <= QUOT_W'(prod >> FRAC);
            r_rem <= rem_full[REM_W-1:0];
            r_quo <= r_est + QUOT_W'(adj);
        end
    end

    assign o_quotient = r_quo;

endmodule

// File: hdl/opp_back.sv
module opp_back
    import opp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_item_valid,
    output logic         o_item_ready,
    input  t_hop_item    i_item,
    output logic         o_res_valid,
    input  logic         i_res_ready,
    output t_result      o_res,
    output t_back_status o_status
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    t_back_state r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [VALUE_W-1:0] r_follower, n_follower;
    logic [VALUE_W-1:0] r_average, n_average;
    logic [VALUE_W-1:0] r_last_onset, n_last_onset;
    logic               r_onset_seen, n_onset_seen;
    t_hop_item          r_cur;
    logic               r_onset;
    logic               r_rise;
    t_result            r_out;
    logic               r_out_valid, n_out_valid;

    logic pop, div_step, commit, out_free;

    logic [VALUE_W+4:0]   value_x20, follower_x21;
    logic                 above_follow, above_avg, gap_ok, onset;
    logic [VALUE_W-1:0]   hop_gap;
    logic [RATE_W-1:0]    rate_c;
    logic [VALUE_W-1:0]   diff;
    logic [ACC_W-1:0]     acc_avg;
    logic [FOL_ACC_W-1:0] acc_fol;
    logic [VALUE_W-1:0]   q_avg, q_fol;
    logic [VALUE_W-1:0]   fol_new, avg_new;

    assign out_free = !r_out_valid || i_res_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_item_ready = 1'b0;
        div_step     = 1'b0;
        commit       = 1'b0;
        unique case (r_state)
            ST_IDLE: o_item_ready = 1'b1;
            ST_DIV:  div_step     = 1'b1;
            ST_DONE: commit       = out_free;
            default: ;
        endcase
    end

    assign pop = o_item_ready && i_item_valid;

    // onset test against the state left by the previous hop
    assign value_x20    = (VALUE_W + 5)'(i_item.value) * (VALUE_W + 5)'(20);
    assign follower_x21 = (VALUE_W + 5)'(r_follower) * (VALUE_W + 5)'(21);
    assign above_follow = value_x20 > follower_x21;
    assign above_avg    = i_item.value > r_average;
    assign hop_gap      = i_item.hop - r_last_onset + VALUE_W'(1);
    assign gap_ok       = !r_onset_seen || (hop_gap > VALUE_W'(i_cfg.min_gap));
    assign onset        = above_follow && above_avg && gap_ok;

    // dividends of the two update divisions
    assign rate_c  = (i_cfg.follow_rate > RATE_MAX) ? RATE_MAX : i_cfg.follow_rate;
    assign diff    = r_follower - i_item.value;
    assign acc_avg = ACC_W'(r_average) * ACC_W'(AVG_GAIN)
                   + ACC_W'(i_item.value) * ACC_W'(DATA_GAIN)
                   + ACC_W'(AVG_ROUND);
    assign acc_fol = FOL_ACC_W'(rate_c) * FOL_ACC_W'(diff) + FOL_ACC_W'(FOLLOW_ROUND);

    opp_cdiv #(
        .DIVIDEND_W (ACC_W),
        .DIVISOR    (AVG_DIVISOR),
        .QUOT_W     (VALUE_W)
    ) u_div_avg (
        .i_clk      (i_clk),
        .i_load     (pop),
        .i_dividend (acc_avg),
        .i_step     (div_step),
        .o_quotient (q_avg)
    );

    opp_cdiv #(
        .DIVIDEND_W (FOL_ACC_W),
        .DIVISOR    (FOLLOW_DIVISOR),
        .QUOT_W     (VALUE_W)
    ) u_div_fol (
        .i_clk      (i_clk),
        .i_load     (pop),
        .i_dividend (acc_fol),
        .i_step     (div_step),
        .o_quotient (q_fol)
    );

    // the new average always fits 32 bits
    assign fol_new = r_rise ? r_cur.value : r_follower - q_fol;
    assign avg_new = q_avg;

    always_comb begin
        n_cnt        = r_cnt;
        n_follower   = r_follower;
        n_average    = r_average;
        n_last_onset = r_last_onset;
        n_onset_seen = r_onset_seen;
        n_out_valid  = r_out_valid;
        if (pop) begin
            n_cnt = '0;
            if (onset) begin
                n_last_onset = i_item.hop;
                n_onset_seen = 1'b1;
            end
        end else if (div_step) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end
        if (commit) begin
            n_follower  = fol_new;
            n_average   = avg_new;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur   <= i_item;
            r_onset <= onset;
            r_rise  <= i_item.value > r_follower;
        end
        if (commit) begin
            r_out.onset    <= r_onset;
            r_out.hop      <= r_cur.hop;
            r_out.follower <= fol_new;
            r_out.peak     <= r_cur.peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_follower   <= '0;
            r_average    <= ONE_FIXED;
            r_last_onset <= '0;
            r_onset_seen <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_follower   <= n_follower;
            r_average    <= n_average;
            r_last_onset <= n_last_onset;
            r_onset_seen <= n_onset_seen;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_res_valid         = r_out_valid;
    assign o_res               = r_out;
    assign o_status.idle       = (r_state == ST_IDLE);
    assign o_status.done       = (r_state == ST_DONE);
    assign o_status.onset_seen = r_onset_seen;

endmodule
